/* sv/rth_pkg.sv */
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types and constants of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rth_pkg;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    localparam int HUE_INT_BITS = 9;
    localparam int DEG_SECTOR   = 60;
    localparam int DEG_GREEN    = 120;
    localparam int DEG_BLUE     = 240;
    localparam int DEG_FULL     = 360;
    localparam int SECTOR_BITS  = 2;

endpackage

/* sv/rgb_to_hsv_converter.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Fixed-point RGB to HSV pixel conversion.
//
// Input queue: drive i_red, i_green, i_blue and raise i_push; the word is
// taken at a rising edge with i_push high and o_full low.
// Result queue: while o_empty is low, o_hue, o_saturation and o_value hold
// the oldest result; it is taken at a rising edge with i_pop high.
// Hue is in 1/2^HUE_FRAC_BITS degree, saturation uses the full channel code
// for 1.0, value is the largest channel.
// Throughput: one pixel per cycle while results are taken.
// From push to o_empty low a pixel passes the front register, the queue,
// the divider input register, D divider stages and the result register;
// D = max(6 + HUE_FRAC_BITS, CHANNEL_BITS) quotient bits, one per stage.
// When the receiver stalls, the divider pipeline holds, the four-word queue
// behind the classify stage fills, and o_full rises.
// Reset (i_rst_n low, synchronous) empties both queues and the pipeline.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS  = 8,
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_push,
    output logic                                       o_full,
    input  logic [CHANNEL_BITS-1:0]                    i_red,
    input  logic [CHANNEL_BITS-1:0]                    i_green,
    input  logic [CHANNEL_BITS-1:0]                    i_blue,
    output logic                                       o_empty,
    input  logic                                       i_pop,
    output logic [rth_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] o_hue,
    output logic [CHANNEL_BITS-1:0]                    o_saturation,
    output logic [CHANNEL_BITS-1:0]                    o_value
);
    import rth_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int HFB = HUE_FRAC_BITS;
    localparam int HW  = HUE_INT_BITS + HFB;
    localparam int D   = ((6 + HFB) > CB) ? (6 + HFB) : CB;
    localparam int W   = CB + D;
    localparam int FW  = SECTOR_BITS + 2 + 2 * CB + 2 * W;
    localparam int QUEUE_DEPTH = 4;

    logic          f_wr, q_full, q_empty, b_rd;
    logic [FW-1:0] f_word, q_word;

    rth_front #(
        .CB (CB),
        .HFB(HFB),
        .W  (W),
        .FW (FW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_wr    (f_wr),
        .o_word  (f_word),
        .i_q_full(q_full)
    );

    rth_fifo #(
        .WIDTH(FW),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (f_wr),
        .i_wdata(f_word),
        .o_full (q_full),
        .i_rd   (b_rd),
        .o_rdata(q_word),
        .o_empty(q_empty)
    );

    rth_back #(
        .CB (CB),
        .HFB(HFB),
        .D  (D),
        .W  (W),
        .FW (FW),
        .HW (HW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (q_word),
        .i_q_empty   (q_empty),
        .o_rd        (b_rd),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_hue       (o_hue),
        .o_saturation(o_saturation),
        .o_value     (o_value)
    );

endmodule

/* sv/rth_fifo.sv */
// ----------------------------------------------------------------------------
// rth_fifo
// Small register queue between the classify front and the divide back.
// ----------------------------------------------------------------------------
module rth_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                do_wr, do_rd;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

/* sv/rth_front.sv */
// ----------------------------------------------------------------------------
// rth_front
// Accepts pixels, finds max, min and hue sector, and forms both dividends.
// ----------------------------------------------------------------------------
module rth_front #(
    parameter int CB = 8,
    parameter int HFB = 6,
    parameter int W = 20,
    parameter int FW = 60
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [CB-1:0] i_red,
    input  logic [CB-1:0] i_green,
    input  logic [CB-1:0] i_blue,
    output logic          o_wr,
    output logic [FW-1:0] o_word,
    input  logic          i_q_full
);
    import rth_pkg::*;

    logic          r_valid;
    logic [FW-1:0] r_word;
    logic [FW-1:0] n_word;
    logic          advance, accept;

    t_sector       sector;
    logic [CB-1:0] mx, mn, delta, op_a, op_b, diff_abs;
    logic          neg, dzero;
    logic [W-1:0]  hue_num, sat_num;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            sector = SEC_RED;
            mx     = i_red;
        end else if (i_green >= i_blue) begin
            sector = SEC_GREEN;
            mx     = i_green;
        end else begin
            sector = SEC_BLUE;
            mx     = i_blue;
        end
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        delta = mx - mn;
        dzero = (delta == '0);
    end

    always_comb begin
        unique case (sector)
            SEC_RED: begin
                op_a = i_green;
                op_b = i_blue;
            end
            SEC_GREEN: begin
                op_a = i_blue;
                op_b = i_red;
            end
            default: begin
                op_a = i_red;
                op_b = i_green;
            end
        endcase
        neg      = (op_a < op_b);
        diff_abs = neg ? (op_b - op_a) : (op_a - op_b);
        // 60 * 2^HFB * |diff| as 64x - 4x
        hue_num  = (W'(diff_abs) << (HFB + 6)) - (W'(diff_abs) << (HFB + 2));
        // full-scale code times delta
        sat_num  = (W'(delta) << CB) - W'(delta);
        n_word   = {sector, neg, dzero, mx, delta, hue_num, sat_num};
    end

    assign o_wr    = r_valid;
    assign o_word  = r_word;
    assign advance = !r_valid || !i_q_full;
    assign o_full  = !advance;
    assign accept  = i_push && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= n_word;
        end
    end

endmodule

/* sv/rth_back.sv */
// ----------------------------------------------------------------------------
// rth_back
// Pipelined restoring dividers for hue offset and saturation, one quotient
// bit per stage, followed by the hue sector combine and the result register.
// ----------------------------------------------------------------------------
module rth_back #(
    parameter int CB = 8,
    parameter int HFB = 6,
    parameter int D = 12,
    parameter int W = 20,
    parameter int FW = 60,
    parameter int HW = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [FW-1:0] i_word,
    input  logic          i_q_empty,
    output logic          o_rd,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [HW-1:0] o_hue,
    output logic [CB-1:0] o_saturation,
    output logic [CB-1:0] o_value
);
    import rth_pkg::*;

    localparam logic [HW-1:0] H_GREEN = HW'(DEG_GREEN << HFB);
    localparam logic [HW-1:0] H_BLUE  = HW'(DEG_BLUE << HFB);
    localparam logic [HW-1:0] H_FULL  = HW'(DEG_FULL << HFB);

    logic                   advance;
    logic                   r_sv   [D+1];
    logic [SECTOR_BITS-1:0] r_sec  [D+1];
    logic                   r_neg  [D+1];
    logic                   r_dz   [D+1];
    logic [CB-1:0]          r_mx   [D+1];
    logic [CB-1:0]          r_dl   [D+1];
    logic [W-1:0]           r_rh   [D+1];
    logic [W-1:0]           r_rs   [D+1];
    logic [D-1:0]           r_qh   [D+1];
    logic [D-1:0]           r_qs   [D+1];

    logic                   r_out_valid;
    logic [HW-1:0]          r_hue, n_hue;
    logic [CB-1:0]          r_sat, n_sat;
    logic [CB-1:0]          r_val;
    logic [HW-1:0]          qh;

    assign advance = !r_out_valid || i_pop;
    assign o_rd    = advance && !i_q_empty;
    assign o_empty = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (advance) begin
            r_sv[0] <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rd) begin
            {r_sec[0], r_neg[0], r_dz[0], r_mx[0], r_dl[0], r_rh[0], r_rs[0]} <= i_word;
            r_qh[0] <= '0;
            r_qs[0] <= '0;
        end
    end

    for (genvar j = 0; j < D; j++) begin : g_stage
        localparam int K = D - 1 - j;
        logic [W-1:0] dh, ds, n_rh, n_rs;
        logic [D-1:0] n_qh, n_qs;

        always_comb begin
            dh   = W'(r_dl[j]) << K;
            ds   = W'(r_mx[j]) << K;
            n_rh = r_rh[j];
            n_rs = r_rs[j];
            n_qh = r_qh[j];
            n_qs = r_qs[j];
            if (r_rh[j] >= dh) begin
                n_rh    = r_rh[j] - dh;
                n_qh[K] = 1'b1;
            end
            if (r_rs[j] >= ds) begin
                n_rs    = r_rs[j] - ds;
                n_qs[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (advance) begin
                r_sv[j+1] <= r_sv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_sec[j+1] <= r_sec[j];
                r_neg[j+1] <= r_neg[j];
                r_dz[j+1]  <= r_dz[j];
                r_mx[j+1]  <= r_mx[j];
                r_dl[j+1]  <= r_dl[j];
                r_rh[j+1]  <= n_rh;
                r_rs[j+1]  <= n_rs;
                r_qh[j+1]  <= n_qh;
                r_qs[j+1]  <= n_qs;
            end
        end
    end

    always_comb begin
        qh    = HW'(r_qh[D]);
        n_sat = CB'(r_qs[D]);
        unique case (t_sector'(r_sec[D]))
            SEC_RED: begin
                if (!r_neg[D]) begin
                    n_hue = qh;
                end else if (qh == '0) begin
                    n_hue = '0;
                end else begin
                    n_hue = H_FULL - qh;
                end
            end
            SEC_GREEN: n_hue = r_neg[D] ? (H_GREEN - qh) : (H_GREEN + qh);
            SEC_BLUE:  n_hue = r_neg[D] ? (H_BLUE - qh) : (H_BLUE + qh);
            default:   n_hue = '0;
        endcase
        if (r_dz[D]) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_sv[D];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= r_mx[D];
        end
    end

    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_value      = r_val;

endmodule
